@@ hdl/asfr_pkg.sv @@
package asfr_pkg;

  // frame store geometry
  localparam int BUFFER_BYTES = 64;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int CMP_W        = 10;

  // frame layout
  localparam int FRAME_OVERHEAD = 5;
  localparam int POS_SENDER     = 1;
  localparam int POS_RECEIVER   = 2;
  localparam int POS_LENGTH     = 3;
  localparam int POS_PAYLOAD    = 4;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 2'd2;

  // configuration reset values
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'hA1;
  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hEA;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'hED;

  // controller to datapath commands
  typedef struct packed {
    logic in_accept;
    logic k_clr;
    logic rd_en;
    logic load_data;
    logic load_empty;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic frame_ok;
    logic len_zero;
    logic last_item;
    logic out_free;
  } status_t;

endpackage

@@ hdl/asfr_dpath.sv @@
module asfr_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  asfr_pkg::cmd_t                 cmd,
  output asfr_pkg::status_t              status,
  input  logic [asfr_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                           cfg_valid,
  input  logic [asfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asfr_pkg::BYTE_W-1:0]    cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [asfr_pkg::BYTE_W-1:0]    out_sender_id,
  output logic [asfr_pkg::LEN_W-1:0]     out_payload_len,
  output logic [asfr_pkg::LEN_W-1:0]     out_byte_pos,
  output logic [asfr_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                           out_empty_payload,
  output logic                           out_last
);

  // configuration registers
  logic [asfr_pkg::BYTE_W-1:0] own_r, start_r, end_r;

  // frame parse state
  logic                        in_frame_r, in_frame_nxt;
  logic [asfr_pkg::CNT_W-1:0]  wc_r, wc_nxt;
  logic [asfr_pkg::BYTE_W-1:0] sender_r, rcv_r, len_r;

  // frame store
  logic [asfr_pkg::BYTE_W-1:0] mem [asfr_pkg::BUFFER_BYTES];
  logic [asfr_pkg::BYTE_W-1:0] rdata_r;

  // readout counter
  logic [asfr_pkg::BYTE_W-1:0] k_r;

  // output register
  logic                        out_valid_r;
  logic [asfr_pkg::BYTE_W-1:0] o_sender_r, o_data_r;
  logic [asfr_pkg::LEN_W-1:0]  o_len_r, o_pos_r;
  logic                        o_empty_r, o_last_r;

  // per-byte parse logic
  logic                        restart, inf, addr_drop, live, ovf, store, is_end;
  logic [asfr_pkg::CNT_W-1:0]  wce, wc1;
  logic [asfr_pkg::ADDR_W-1:0] rd_addr;

  always_comb begin
    restart   = (in_rx_byte == start_r);
    inf       = restart | in_frame_r;
    wce       = restart ? '0 : wc_r;
    addr_drop = inf & (wce >= asfr_pkg::CNT_W'(asfr_pkg::POS_LENGTH)) & (rcv_r != own_r);
    live      = inf & ~addr_drop;
    ovf       = live & (wce >= asfr_pkg::CNT_W'(asfr_pkg::BUFFER_BYTES));
    store     = live & ~ovf;
    wc1       = wce + asfr_pkg::CNT_W'(1);
    is_end    = (in_rx_byte == end_r);
    if (store & ~is_end) begin
      in_frame_nxt = 1'b1;
      wc_nxt       = wc1;
    end else begin
      in_frame_nxt = 1'b0;
      wc_nxt       = '0;
    end
  end

  // status towards the controller
  always_comb begin
    status.frame_ok  = store & is_end &
                       (asfr_pkg::CMP_W'(wc1) ==
                        asfr_pkg::CMP_W'(len_r) + asfr_pkg::CMP_W'(asfr_pkg::FRAME_OVERHEAD));
    status.len_zero  = (len_r == '0);
    status.last_item = (k_r + asfr_pkg::BYTE_W'(1)) == len_r;
    status.out_free  = ~out_valid_r | ~out_stall;
  end

  assign rd_addr = asfr_pkg::ADDR_W'(k_r + asfr_pkg::BYTE_W'(asfr_pkg::POS_PAYLOAD));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= asfr_pkg::OWN_ADDRESS_RST;
      start_r <= asfr_pkg::START_BYTE_RST;
      end_r   <= asfr_pkg::END_BYTE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        asfr_pkg::CFG_OWN_ADDRESS: own_r   <= cfg_data;
        asfr_pkg::CFG_START_BYTE:  start_r <= cfg_data;
        asfr_pkg::CFG_END_BYTE:    end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // parse control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      wc_r       <= '0;
    end else if (cmd.in_accept) begin
      in_frame_r <= in_frame_nxt;
      wc_r       <= wc_nxt;
    end
  end

  // header bytes
  always_ff @(posedge clk) begin
    if (cmd.in_accept && store) begin
      if (wce == asfr_pkg::CNT_W'(asfr_pkg::POS_SENDER)) begin
        sender_r <= in_rx_byte;
      end
      if (wce == asfr_pkg::CNT_W'(asfr_pkg::POS_RECEIVER)) begin
        rcv_r <= in_rx_byte;
      end
      if (wce == asfr_pkg::CNT_W'(asfr_pkg::POS_LENGTH)) begin
        len_r <= in_rx_byte;
      end
    end
  end

  // frame store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.in_accept && store) begin
      mem[wce[asfr_pkg::ADDR_W-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // payload position counter
  always_ff @(posedge clk) begin
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.load_data) begin
      k_r <= k_r + asfr_pkg::BYTE_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_data || cmd.load_empty) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) begin
      o_sender_r <= sender_r;
      o_len_r    <= len_r[asfr_pkg::LEN_W-1:0];
      o_pos_r    <= k_r[asfr_pkg::LEN_W-1:0];
      o_data_r   <= rdata_r;
      o_empty_r  <= 1'b0;
      o_last_r   <= status.last_item;
    end else if (cmd.load_empty) begin
      o_sender_r <= sender_r;
      o_len_r    <= '0;
      o_pos_r    <= '0;
      o_data_r   <= '0;
      o_empty_r  <= 1'b1;
      o_last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sender_id     = o_sender_r;
  assign out_payload_len   = o_len_r;
  assign out_byte_pos      = o_pos_r;
  assign out_data_byte     = o_data_r;
  assign out_empty_payload = o_empty_r;
  assign out_last          = o_last_r;

`ifndef NO_ASSERTIONS
  // byte count never runs past the store
  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= asfr_pkg::CNT_W'(asfr_pkg::BUFFER_BYTES))
    else $error("frame byte count beyond buffer");

  // count is cleared whenever no frame is open
  a_wc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> wc_r == '0)
    else $error("byte count left over outside a frame");
`endif

endmodule

@@ hdl/asfr_ctrl.sv @@
module asfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  asfr_pkg::status_t status,
  output asfr_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SHOW  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    cmd.in_accept  = 1'b0;
    cmd.k_clr      = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.load_data  = 1'b0;
    cmd.load_empty = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.in_accept = in_valid;
        if (in_valid && status.frame_ok) begin
          cmd.k_clr = 1'b1;
          state_nxt = status.len_zero ? ST_EMPTY : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (status.out_free) begin
          cmd.load_data = 1'b1;
          state_nxt     = status.last_item ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a good frame end always starts a readout
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && status.frame_ok) |=> state_r != ST_IDLE)
    else $error("accepted frame did not start readout");

  // final payload transfer returns to idle
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHOW && status.out_free && status.last_item) |=> state_r == ST_IDLE)
    else $error("readout ran past last payload byte");
`endif

endmodule

@@ hdl/addressed_serial_frame_receiver.sv @@
// Addressed serial frame receiver.
// Input channel: one received byte per transfer (in_valid / in_stall).
// Frames are start byte, sender, receiver, length, payload, end byte.
// Output channel: one transfer per payload byte of an accepted frame,
// carrying sender, length, position, data and a last mark; a frame with
// no payload gives a single transfer flagged empty.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data,
// index 0 own address, 1 start byte, 2 end byte; cfg_ready is always high.
// Throughput: one byte per cycle while parsing. On a good end byte the
// input stalls for readout: each payload byte is first read from the frame
// store into a register and then loaded into the output register, one byte
// after the other (an empty frame loads its result directly). The input
// stays stalled until the last result of the frame is loaded, longer if the
// output stalls.
// A stalled output holds its result; further input bytes are still taken
// while the last result of a frame waits.
// Reset: no frame open, registers back to 0xA1, 0xEA, 0xED, output empty.
module addressed_serial_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [asfr_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [asfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asfr_pkg::BYTE_W-1:0]    cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [asfr_pkg::BYTE_W-1:0]    out_sender_id,
  output logic [asfr_pkg::LEN_W-1:0]     out_payload_len,
  output logic [asfr_pkg::LEN_W-1:0]     out_byte_pos,
  output logic [asfr_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                           out_empty_payload,
  output logic                           out_last
);

  asfr_pkg::cmd_t    cmd;
  asfr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  asfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // parser, frame store and output register
  asfr_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_rx_byte        (in_rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sender_id     (out_sender_id),
    .out_payload_len   (out_payload_len),
    .out_byte_pos      (out_byte_pos),
    .out_data_byte     (out_data_byte),
    .out_empty_payload (out_empty_payload),
    .out_last          (out_last)
  );

endmodule

@@ bench/addressed_serial_frame_receiver_test.sv @@
`timescale 1ns / 100ps

module addressed_serial_frame_receiver_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 130;
  localparam int PHASE_BYTES    = 24;

  // one payload transfer of an accepted frame
  typedef struct packed {
    logic [asfr_pkg::BYTE_W-1:0] sender_id;
    logic [asfr_pkg::LEN_W-1:0]  payload_len;
    logic [asfr_pkg::LEN_W-1:0]  byte_pos;
    logic [asfr_pkg::BYTE_W-1:0] data_byte;
    logic                        empty_payload;
    logic                        last;
  } payload_xfer_t;

  // malformed or rejected frame shapes
  typedef enum int {
    BF_WRONG_RX, BF_EARLY_END, BF_LATE_END, BF_END_IN_HEADER,
    BF_RESTART, BF_BIG_LEN, BF_OVERRUN
  } broken_frame_e;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RHYTHM, STALL_HEAVY} stall_mode_e;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [asfr_pkg::BYTE_W-1:0]    in_rx_byte = '0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [asfr_pkg::CFG_IDX_W-1:0] cfg_index = asfr_pkg::CFG_OWN_ADDRESS;
  logic [asfr_pkg::BYTE_W-1:0]    cfg_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [asfr_pkg::BYTE_W-1:0]    out_sender_id;
  logic [asfr_pkg::LEN_W-1:0]     out_payload_len;
  logic [asfr_pkg::LEN_W-1:0]     out_byte_pos;
  logic [asfr_pkg::BYTE_W-1:0]    out_data_byte;
  logic                           out_empty_payload;
  logic                           out_last;

  addressed_serial_frame_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sender_id     (out_sender_id),
    .out_payload_len   (out_payload_len),
    .out_byte_pos      (out_byte_pos),
    .out_data_byte     (out_data_byte),
    .out_empty_payload (out_empty_payload),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser copy: registers, frame state and store
  logic [asfr_pkg::BYTE_W-1:0] own_now   = asfr_pkg::OWN_ADDRESS_RST;
  logic [asfr_pkg::BYTE_W-1:0] start_now = asfr_pkg::START_BYTE_RST;
  logic [asfr_pkg::BYTE_W-1:0] end_now   = asfr_pkg::END_BYTE_RST;
  bit                          frame_open = 1'b0;
  int                          stored_count = 0;
  logic [asfr_pkg::BYTE_W-1:0] frame_bytes [asfr_pkg::BUFFER_BYTES];

  logic [asfr_pkg::BYTE_W-1:0] rx_stream_q [$];
  payload_xfer_t               payload_due_q [$];
  int                          frame_bytes_queued = 0;
  int                          fail_count = 0;
  bit                          rx_taken = 1'b0;
  bit                          hold_armed = 1'b0;

  // reset settings: empty frame, one-byte frame, then rejected frames
  logic [asfr_pkg::BYTE_W-1:0] opening_bytes [25] = '{
    8'h00, 8'hFF,
    8'hEA, 8'h00, 8'hA1, 8'h00, 8'hED,
    8'hEA, 8'hFF, 8'hA1, 8'h01, 8'hFF, 8'hED,
    8'hEA, 8'h12, 8'hA0, 8'h01, 8'hED,
    8'hEA, 8'hED,
    8'hEA, 8'h01, 8'hA1, 8'h02, 8'hED
  };
  // own address, start byte, end byte per phase
  logic [asfr_pkg::BYTE_W-1:0] settings_table [5][3] = '{
    '{8'hA1, 8'hEA, 8'hED},
    '{8'h00, 8'hFF, 8'h80},
    '{8'hFF, 8'h00, 8'h7E},
    '{8'h5A, 8'h81, 8'h00},
    '{8'h3C, 8'h42, 8'hFF}
  };

  // parse one received byte and queue the payload transfers it releases
  function automatic void parse_rx_byte(input logic [asfr_pkg::BYTE_W-1:0] b);
    payload_xfer_t x;
    int            total;
    int            len;
    if (b == start_now) begin
      frame_open   = 1'b1;
      stored_count = 0;
    end
    // receiver byte is checked from the fourth byte on
    if (frame_open && stored_count >= 3 &&
        frame_bytes[asfr_pkg::POS_RECEIVER] != own_now) begin
      frame_open   = 1'b0;
      stored_count = 0;
    end
    if (!frame_open) return;
    // overrun aborts the frame
    if (stored_count >= asfr_pkg::BUFFER_BYTES) begin
      frame_open   = 1'b0;
      stored_count = 0;
      return;
    end
    frame_bytes[stored_count] = b;
    stored_count++;
    if (b != end_now) return;
    frame_open   = 1'b0;
    total        = stored_count;
    stored_count = 0;
    if (total < asfr_pkg::FRAME_OVERHEAD) return;
    len = int'(frame_bytes[asfr_pkg::POS_LENGTH]);
    if (total != asfr_pkg::FRAME_OVERHEAD + len) return;
    x.sender_id   = frame_bytes[asfr_pkg::POS_SENDER];
    x.payload_len = frame_bytes[asfr_pkg::POS_LENGTH][asfr_pkg::LEN_W-1:0];
    if (len == 0) begin
      x.byte_pos      = '0;
      x.data_byte     = '0;
      x.empty_payload = 1'b1;
      x.last          = 1'b1;
      payload_due_q.push_back(x);
      return;
    end
    x.empty_payload = 1'b0;
    for (int k = 0; k < len; k++) begin
      x.byte_pos  = asfr_pkg::LEN_W'(k);
      x.data_byte = frame_bytes[asfr_pkg::POS_PAYLOAD + k];
      x.last      = (k + 1 == len);
      payload_due_q.push_back(x);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // sender: bursts of random length with random gaps, payload held while stalled
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!in_valid || rx_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (rx_stream_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_stream_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end
    end
    rx_taken = 1'b0;
  end

  // receiver stall pattern, with an occasional long hold-off
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_tick = 0;
  int          hold_left  = 0;

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_armed && out_valid) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_RHYTHM: out_stall <= (stall_tick % 3 == 0);
        default:      out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // transfers on both channels, result check and watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin : transfer_monitor
    payload_xfer_t want;
    bit            moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      parse_rx_byte(rx_stream_q.pop_front());
      rx_taken = 1'b1;
      moved    = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (payload_due_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual sender %0h pos %0h data %0h",
                 $time, out_sender_id, out_byte_pos, out_data_byte);
        fail_count++;
      end else begin
        want = payload_due_q.pop_front();
        check_field("sender_id", 32'(want.sender_id), 32'(out_sender_id));
        check_field("payload_len", 32'(want.payload_len), 32'(out_payload_len));
        check_field("byte_pos", 32'(want.byte_pos), 32'(out_byte_pos));
        check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
        check_field("empty_payload", 32'(want.empty_payload), 32'(out_empty_payload));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
    if (cfg_valid && cfg_ready) moved = 1'b1;
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus building
  function automatic void push_frame_byte(input logic [asfr_pkg::BYTE_W-1:0] b);
    rx_stream_q.push_back(b);
    frame_bytes_queued++;
  endfunction

  // random byte that neither opens nor closes a frame
  function automatic logic [asfr_pkg::BYTE_W-1:0] plain_byte();
    logic [asfr_pkg::BYTE_W-1:0] b;
    do b = asfr_pkg::BYTE_W'($urandom_range(0, 255)); while (b == start_now || b == end_now);
    return b;
  endfunction

  function automatic void queue_header(input logic [asfr_pkg::BYTE_W-1:0] rx_addr,
                                       input logic [asfr_pkg::BYTE_W-1:0] len);
    push_frame_byte(start_now);
    push_frame_byte(plain_byte());
    push_frame_byte(rx_addr);
    push_frame_byte(len);
  endfunction

  function automatic void queue_good_frame(input int len);
    queue_header(own_now, asfr_pkg::BYTE_W'(len));
    repeat (len) push_frame_byte(plain_byte());
    push_frame_byte(end_now);
  endfunction

  // mostly short payloads, now and then the largest that fit
  function automatic int random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(58, 59);
    if (r < 70) return $urandom_range(0, 4);
    return $urandom_range(5, 20);
  endfunction

  function automatic void queue_broken_frame(input broken_frame_e kind);
    logic [asfr_pkg::BYTE_W-1:0] b;
    int                          len;
    case (kind)
      BF_WRONG_RX: begin
        do b = plain_byte(); while (b == own_now);
        len = $urandom_range(0, 4);
        queue_header(b, asfr_pkg::BYTE_W'(len));
        repeat (len) push_frame_byte(plain_byte());
        push_frame_byte(end_now);
      end
      BF_EARLY_END: begin
        len = $urandom_range(1, 6);
        queue_header(own_now, asfr_pkg::BYTE_W'(len));
        repeat ($urandom_range(0, len - 1)) push_frame_byte(plain_byte());
        push_frame_byte(end_now);
      end
      BF_LATE_END: begin
        len = $urandom_range(0, 6);
        queue_header(own_now, asfr_pkg::BYTE_W'(len));
        repeat (len + $urandom_range(1, 3)) push_frame_byte(plain_byte());
        push_frame_byte(end_now);
      end
      BF_END_IN_HEADER: begin
        push_frame_byte(start_now);
        repeat ($urandom_range(0, 2)) push_frame_byte(plain_byte());
        push_frame_byte(end_now);
      end
      BF_RESTART: begin
        len = $urandom_range(2, 8);
        queue_header(own_now, asfr_pkg::BYTE_W'(len));
        repeat ($urandom_range(1, len - 1)) push_frame_byte(plain_byte());
        queue_good_frame($urandom_range(0, 6));
      end
      BF_BIG_LEN: begin
        do b = asfr_pkg::BYTE_W'($urandom_range(60, 255));
        while (b == start_now || b == end_now);
        queue_header(own_now, b);
        repeat ($urandom_range(0, 4)) push_frame_byte(plain_byte());
        push_frame_byte(end_now);
      end
      default: begin
        // store fills up; just at the boundary the frame may still fit
        queue_header(own_now, asfr_pkg::BYTE_W'($urandom_range(56, 59)));
        repeat ($urandom_range(59, 62)) push_frame_byte(plain_byte());
        push_frame_byte(end_now);
      end
    endcase
  endfunction

  function automatic void queue_random_phase(input bit with_max, input bit with_overrun);
    int first;
    int pick;
    if (with_max) queue_good_frame(59);
    if (with_overrun) queue_broken_frame(BF_OVERRUN);
    first = frame_bytes_queued;
    while (frame_bytes_queued - first < PHASE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        queue_good_frame(random_len());
      end else if (pick < 68) begin
        // noise between frames
        repeat ($urandom_range(1, 4)) begin
          rx_stream_q.push_back(plain_byte());
          if ($urandom_range(0, 3) == 0) rx_stream_q.push_back(end_now);
        end
      end else begin
        queue_broken_frame(broken_frame_e'($urandom_range(BF_WRONG_RX, BF_OVERRUN)));
      end
    end
  endfunction

  task automatic write_register(input logic [asfr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [asfr_pkg::BYTE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      asfr_pkg::CFG_OWN_ADDRESS: own_now   = value;
      asfr_pkg::CFG_START_BYTE:  start_now = value;
      asfr_pkg::CFG_END_BYTE:    end_now   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all bytes sent, all transfers seen, then let the block settle
  task automatic wait_quiet();
    while (rx_stream_q.size() != 0 || in_valid || payload_due_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_bytes[i]) rx_stream_q.push_back(opening_bytes[i]);
    wait_quiet();

    for (int p = 0; p < 5; p++) begin
      write_register(asfr_pkg::CFG_OWN_ADDRESS, settings_table[p][0]);
      write_register(asfr_pkg::CFG_START_BYTE, settings_table[p][1]);
      write_register(asfr_pkg::CFG_END_BYTE, settings_table[p][2]);
      @(posedge clk);
      // long output hold-off while the sender keeps offering bytes
      if (p == 1 || p == 3) hold_armed = 1'b1;
      queue_random_phase(p == 1, p == 3);
      wait_quiet();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/asfr_pkg.sv
hdl/asfr_dpath.sv
hdl/asfr_ctrl.sv
hdl/addressed_serial_frame_receiver.sv
bench/addressed_serial_frame_receiver_test.sv
